@@ src/prr_pkg.sv @@
// Shared types and constants for the polyphase rational resampler.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

   // Fixed field widths of the request and response items.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int PHASE_W  = 9;
   localparam int SHIFT_W  = 5;
   localparam int TAPS_W   = 8;

   // Depth of the request queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;

   // Request mode codes carried on tuser.
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_COEF   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Register indexes on the CSR port.
   localparam logic [1:0] REG_INTERP = 2'd0;
   localparam logic [1:0] REG_DECIM  = 2'd1;
   localparam logic [1:0] REG_TAPS   = 2'd2;
   localparam logic [1:0] REG_SHIFT  = 2'd3;

   // Saturation limits of the output sample.
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

   // Kind of a request after classification.
   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_COEF,
      KIND_CLEAR
   } kind_type;

   // One queued request.
   typedef struct packed {
      kind_type                   kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [7:0]                 coef_phase;
      logic [4:0]                 coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } entry_type;

   // Clamped configuration seen by the back end.
   typedef struct packed {
      logic [PHASE_W-1:0] interp;
      logic [PHASE_W-1:0] decim;
      logic [TAPS_W-1:0]  taps;
      logic [SHIFT_W-1:0] shift;
   } cfg_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_PREP,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT,
      ST_SKIP,
      ST_WRAP
   } state_type;

endpackage

`default_nettype wire

@@ src/prr_csr.sv @@
// Configuration registers with APB-style access and range clamping.
`timescale 1ns / 1ps
`default_nettype none

module prr_csr #(
   parameter int MAX_TAPS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output prr_pkg::cfg_type cfg
);
   import prr_pkg::*;

   localparam logic [TAPS_W-1:0] TAPS_HI = TAPS_W'(MAX_TAPS);

   logic [PHASE_W-1:0] interp_ff, interp_in;
   logic [PHASE_W-1:0] decim_ff, decim_in;
   logic [5:0]         taps_ff, taps_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               wr_en;
   logic [1:0]         reg_idx;
   logic [TAPS_W-1:0]  taps_wide;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode.
   always_comb begin
      interp_in = interp_ff;
      decim_in  = decim_ff;
      taps_in   = taps_ff;
      shift_in  = shift_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INTERP: interp_in = csr_pwdata[PHASE_W-1:0];
            REG_DECIM:  decim_in  = csr_pwdata[PHASE_W-1:0];
            REG_TAPS:   taps_in   = csr_pwdata[5:0];
            REG_SHIFT:  shift_in  = csr_pwdata[SHIFT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= 9'd160;
         decim_ff  <= 9'd147;
         taps_ff   <= 6'd32;
         shift_ff  <= 5'd14;
      end else begin
         interp_ff <= interp_in;
         decim_ff  <= decim_in;
         taps_ff   <= taps_in;
         shift_ff  <= shift_in;
      end
   end

   // Register read mux.
   always_comb begin
      unique case (reg_idx)
         REG_INTERP: csr_prdata = {23'd0, interp_ff};
         REG_DECIM:  csr_prdata = {23'd0, decim_ff};
         REG_TAPS:   csr_prdata = {26'd0, taps_ff};
         REG_SHIFT:  csr_prdata = {27'd0, shift_ff};
      endcase
   end

   // Factors act within 1..256 and the tap count within 4..MAX_TAPS.
   assign taps_wide = {2'd0, taps_ff};

   always_comb begin
      cfg.interp = (interp_ff == 9'd0) ? 9'd1 : (interp_ff > 9'd256) ? 9'd256 : interp_ff;
      cfg.decim  = (decim_ff == 9'd0) ? 9'd1 : (decim_ff > 9'd256) ? 9'd256 : decim_ff;
      cfg.taps   = (taps_wide < 8'd4) ? 8'd4 : (taps_wide > TAPS_HI) ? TAPS_HI : taps_wide;
      cfg.shift  = shift_ff;
   end

endmodule

`default_nettype wire

@@ src/prr_front.sv @@
// Front end: accepts requests, classifies them and queues the ones that matter.
`timescale 1ns / 1ps
`default_nettype none

module prr_front #(
   parameter int MAX_PHASES = 256,
   parameter int MAX_TAPS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               q_valid,
   output prr_pkg::entry_type q_entry,
   input  logic               q_pop
);
   import prr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        q_mem_ff [QUEUE_DEPTH];
   entry_type        cls;
   logic             keep;
   logic             push;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Classification: unknown modes and out-of-range coefficient writes are dropped.
   always_comb begin
      cls.sample     = req_tdata[15:0];
      cls.coef_phase = req_tdata[23:16];
      cls.coef_index = req_tdata[28:24];
      cls.coef_value = req_tdata[46:29];
      unique case (req_tuser)
         MODE_SAMPLE: begin
            cls.kind = KIND_SAMPLE;
            keep     = 1'b1;
         end
         MODE_COEF: begin
            cls.kind = KIND_COEF;
            keep     = (32'(cls.coef_phase) < MAX_PHASES) && (32'(cls.coef_index) < MAX_TAPS);
         end
         MODE_CLEAR: begin
            cls.kind = KIND_CLEAR;
            keep     = 1'b1;
         end
         default: begin
            cls.kind = KIND_SAMPLE;
            keep     = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != FULL);
   assign push       = req_tvalid & req_tready & keep;
   assign q_valid    = (count_ff != '0);
   assign q_entry    = q_mem_ff[rd_ptr_ff];

   // Queue pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

@@ src/prr_back.sv @@
// Back end: delay line, coefficient memory, shared MAC and output register.
`timescale 1ns / 1ps
`default_nettype none

module prr_back #(
   parameter int MAX_PHASES  = 256,
   parameter int MAX_TAPS    = 32,
   parameter int MAX_OUTPUTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  prr_pkg::entry_type q_entry,
   output logic               q_pop,
   input  prr_pkg::cfg_type   cfg,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);
   import prr_pkg::*;

   localparam int TAP_W     = $clog2(MAX_TAPS);
   localparam int PH_W      = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int ADDR_W    = PH_W + TAP_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = PROD_W + TAP_W;
   localparam int RND_W     = ACC_W + 1;
   localparam int N_W       = $clog2(MAX_OUTPUTS + 1);
   localparam int CAP_W     = N_W + 10;
   localparam logic [N_W-1:0] N_LAST = N_W'(MAX_OUTPUTS - 1);
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
   localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(32768);

   // Sequencer and item state.
   state_type                  state_ff, state_in;
   logic [TAP_W-1:0]           wp_ff, wp_in;
   logic [TAP_W-1:0]           newest_ff, newest_in;
   logic [TAP_W-1:0]           src_ff, src_in;
   logic [TAP_W-1:0]           k_ff, k_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [N_W-1:0]             n_ff, n_in;
   logic                       capped_ff, capped_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [RND_W-1:0]    rnd_ff, rnd_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [1:0]                 rsp_user_ff, rsp_user_in;

   // MAC pipeline.
   logic                       v1_ff, v2_ff;
   logic                       zero_ff;
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic signed [PROD_W-1:0]   prod_full;
   logic signed [PROD_W-1:0]   prod_ff;

   // Storage.
   logic signed [SAMPLE_W-1:0] hist_ff [MAX_TAPS];
   logic signed [COEF_W-1:0]   coef_mem [MEM_DEPTH];

   // Control decoded by the sequencer.
   logic                       issue;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_wa;
   logic [ADDR_W-1:0]          mem_ra;
   logic                       hist_we;
   logic                       hist_clr;
   logic                       out_free;
   logic                       phase_big;
   logic [PHASE_W-1:0]         psum;
   logic                       psum_done;
   logic [CAP_W-1:0]           cap_sum;
   logic signed [RND_W-1:0]    bias;
   logic signed [RND_W-1:0]    shifted;
   logic                       sat_hi;
   logic                       sat_lo;
   logic [15:0]                y;
   logic                       last_out;

   // Shared arithmetic of the sequencer.
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign phase_big = 32'(phase_ff) >= MAX_PHASES;
   assign psum      = phase_ff + cfg.decim;
   assign psum_done = psum >= cfg.interp;
   assign cap_sum   = CAP_W'(phase_ff) + CAP_W'(MAX_OUTPUTS) * CAP_W'(cfg.decim);
   assign bias      = (cfg.shift == '0) ? '0 : (RND_W'(1) <<< (cfg.shift - 5'd1));
   assign shifted   = rnd_ff >>> cfg.shift;
   assign sat_hi    = shifted > SAT_HI;
   assign sat_lo    = shifted < SAT_LO;
   assign y         = sat_hi ? OUT_MAX : sat_lo ? OUT_MIN : shifted[15:0];
   assign last_out  = (n_ff == N_LAST) || psum_done;
   assign mem_wa    = {PH_W'(q_entry.coef_phase), TAP_W'(q_entry.coef_index)};
   assign mem_ra    = {PH_W'(phase_ff), k_ff};

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      newest_in    = newest_ff;
      src_in       = src_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      capped_in    = capped_ff;
      sample_in    = sample_ff;
      acc_in       = v2_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop        = 1'b0;
      issue        = 1'b0;
      mem_we       = 1'b0;
      hist_we      = 1'b0;
      hist_clr     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.kind)
                  KIND_COEF: begin
                     mem_we = 1'b1;
                  end
                  KIND_CLEAR: begin
                     hist_clr = 1'b1;
                     wp_in    = '0;
                     phase_in = '0;
                  end
                  default: begin
                     sample_in = q_entry.sample;
                     state_in  = ST_NORM;
                  end
               endcase
            end
         end

         // Fold a stale write position into the taps in use, then store the sample.
         ST_NORM: begin
            if (TAPS_W'(wp_ff) >= cfg.taps) begin
               wp_in = TAP_W'(TAPS_W'(wp_ff) - cfg.taps);
            end else begin
               hist_we   = 1'b1;
               newest_in = wp_ff;
               wp_in     = (TAPS_W'(wp_ff) + 8'd1 == cfg.taps) ? '0 : wp_ff + 1'b1;
               state_in  = ST_PREP;
            end
         end

         ST_PREP: begin
            n_in      = '0;
            capped_in = cap_sum < CAP_W'(cfg.interp);
            if (phase_ff >= cfg.interp) begin
               state_in = ST_WRAP;
            end else begin
               acc_in   = '0;
               k_in     = '0;
               src_in   = newest_ff;
               state_in = ST_MAC;
            end
         end

         // One tap per cycle, newest sample first.
         ST_MAC: begin
            issue  = 1'b1;
            k_in   = k_ff + 1'b1;
            src_in = (src_ff == '0) ? TAP_W'(cfg.taps - 8'd1) : src_ff - 1'b1;
            if (TAPS_W'(k_ff) + 8'd1 == cfg.taps) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            rnd_in   = RND_W'(acc_ff) + bias;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y;
               rsp_last_in  = last_out;
               rsp_user_in  = {capped_ff, sat_hi | sat_lo};
               phase_in     = psum;
               n_in         = n_ff + 1'b1;
               if (!last_out) begin
                  acc_in   = '0;
                  k_in     = '0;
                  src_in   = newest_ff;
                  state_in = ST_MAC;
               end else if (psum_done) begin
                  state_in = ST_WRAP;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end

         // Advance the phase past the dropped outputs.
         ST_SKIP: begin
            if (phase_ff < cfg.interp) begin
               phase_in = psum;
            end else begin
               state_in = ST_WRAP;
            end
         end

         ST_WRAP: begin
            phase_in = phase_ff - cfg.interp;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      src_ff      <= src_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      capped_ff   <= capped_in;
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      rnd_ff      <= rnd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Delay line: cleared by reset and by a clear request.
   always_ff @(posedge clock) begin
      if (reset || hist_clr) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (hist_we) begin
         hist_ff[wp_ff] <= sample_ff;
      end
   end

   // Coefficient memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[mem_wa] <= q_entry.coef_value;
      end
      coef_rd_ff <= coef_mem[mem_ra];
   end

   // MAC operand fetch and product stage; branches beyond the table read zero.
   assign prod_full = hist_rd_ff * coef_rd_ff;

   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_ff[src_ff];
      zero_ff    <= phase_big;
      prod_ff    <= zero_ff ? '0 : prod_full;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ src/polyphase_rational_resampler.sv @@
// Top level of the rational L/M polyphase resampler.
//
//  Channel   Direction  Handshake               Carries
//  req_*     in         tvalid/tready           samples, coefficient writes, clears
//  rsp_*     out        tvalid/tready           rounded, saturated output samples
//  csr_*     in         psel/penable/pready     L, M, taps per phase, output shift
//
// In the back end a sample runs one MAC pass over the T taps in use for each of
// the n outputs it produces; one MAC does one tap per cycle. Dropped outputs
// beyond the cap still step the phase, one step each. Coefficient writes and
// clears are handled directly from idle. A four-entry request queue lets
// requests enter while the MAC works; a full output register stalls the back end.
// Reset is synchronous and clears the delay line, phase and write position.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler #(
   parameter int MAX_PHASES  = 256,
   parameter int MAX_TAPS    = 32,
   parameter int MAX_OUTPUTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample, coef_phase, coef_index, coef_value, pad
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_sample
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // saturated, capped
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import prr_pkg::*;

   cfg_type   cfg;
   entry_type q_entry;
   logic      q_valid;
   logic      q_pop;

   prr_csr #(
      .MAX_TAPS(MAX_TAPS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prr_front #(
      .MAX_PHASES(MAX_PHASES),
      .MAX_TAPS  (MAX_TAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   prr_back #(
      .MAX_PHASES (MAX_PHASES),
      .MAX_TAPS   (MAX_TAPS),
      .MAX_OUTPUTS(MAX_OUTPUTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The back end only takes a request that the queue holds.
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("request popped from an empty queue");

   // An empty queue always has room for a new request.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> req_tready)
      else $error("request stalled while the queue is empty");

   // The clamped configuration stays inside its working range.
   a_cfg_clamped: assert property (@(posedge clock) disable iff (reset)
      cfg.interp != 9'd0 && cfg.interp <= 9'd256 && cfg.decim != 9'd0 &&
      cfg.decim <= 9'd256 && cfg.taps >= 8'd4)
      else $error("configuration outside its clamped range");

endmodule

`default_nettype wire

@@ tb/tb_polyphase_rational_resampler.sv @@
// Self-checking testbench for the polyphase rational resampler: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_polyphase_rational_resampler;
   import prr_pkg::*;

   localparam int MAX_PHASES   = 256;
   localparam int MAX_TAPS     = 32;
   localparam int MAX_OUTPUTS  = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int NUM_DIRECTED = 17;
   localparam int NUM_SETTINGS = 9;

   // Mode code that the block must ignore.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // One expected output of the resampler.
   typedef struct packed {
      logic signed [15:0] out_sample;
      logic               last;
      logic               saturated;
      logic               capped;
   } resample_out_t;

   // One row of the directed table; the known_* fields hold values read off by hand.
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] sample;
      logic [7:0]  coef_phase;
      logic [4:0]  coef_index;
      logic [17:0] coef_value;
      logic        known;
      logic [4:0]  known_count;
      logic [15:0] known_sample;
      logic        known_sat;
   } stim_row_t;

   // One register setting and the number of random requests run under it.
   typedef struct packed {
      logic [31:0] interp;
      logic [31:0] decim;
      logic [31:0] taps;
      logic [31:0] shift;
      logic [15:0] requests;
   } setting_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // sample, coef_phase, coef_index, coef_value, pad
   logic [1:0]  req_tuser = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // out_sample
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;        // saturated, capped
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: configuration, delay line, phase and coefficient store.
   logic [8:0]         cfg_interp = 9'd160;
   logic [8:0]         cfg_decim  = 9'd147;
   logic [5:0]         cfg_taps   = 6'd32;
   logic [4:0]         cfg_shift  = 5'd14;
   logic signed [15:0] hist_line [MAX_TAPS] = '{default: '0};
   logic signed [17:0] coef_store [MAX_PHASES * MAX_TAPS] = '{default: '0};
   int                 hist_pos = 0;
   int                 phase_now = 0;

   resample_out_t expected_outputs [$];
   resample_out_t head_output;
   int            error_count = 0;
   int            cycle_count = 0;
   int            stall_left = 0;
   logic          quiet = 1'b0;

   polyphase_rational_resampler #(
      .MAX_PHASES (MAX_PHASES),
      .MAX_TAPS   (MAX_TAPS),
      .MAX_OUTPUTS(MAX_OUTPUTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("%s", msg);
   endfunction

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Idle length: mostly none, some short, a few long; none during quiet stretches.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [47:0] pack_request(input logic [15:0] sample,
                                                input logic [7:0] coef_phase,
                                                input logic [4:0] coef_index,
                                                input logic [17:0] coef_value);
      return {1'b0, coef_value, coef_index, coef_phase, sample};
   endfunction

   // Quiet stretches switch on and off at random.
   always @(posedge clock) begin
      if ($urandom_range(0, 249) == 0)
         quiet <= !quiet;
   end

   // Receiver back-pressure with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left <= idle_gap();
      end
   end

   // Compare every accepted output with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            note_error($sformatf("unexpected output: sample %h last %b flags %b",
                                 rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            head_output = expected_outputs.pop_front();
            if (rsp_tdata !== head_output.out_sample || rsp_tlast !== head_output.last ||
                rsp_tuser !== {head_output.capped, head_output.saturated})
               note_error($sformatf(
                  "output mismatch: expected %h last %b sat %b capped %b, got %h %b %b %b",
                  head_output.out_sample, head_output.last, head_output.saturated,
                  head_output.capped, rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1]));
         end
      end
   end

   // Resample one input sample and queue the outputs that it causes.
   task automatic resample_input(input logic signed [15:0] value, output int produced,
                                 output resample_out_t first_out);
      int            interp;
      int            decim;
      int            taps;
      int            newest;
      int            total;
      int            k;
      int            src;
      longint        acc;
      logic          capped;
      resample_out_t item;
      resample_out_t batch [$];
      interp = clamp_int(cfg_interp, 1, 256);
      decim  = clamp_int(cfg_decim, 1, 256);
      taps   = clamp_int(cfg_taps, 4, MAX_TAPS);
      // A shrunken delay line wraps the stale write position.
      newest = hist_pos % taps;
      hist_line[newest] = value;
      hist_pos = (newest + 1) % taps;
      total = (phase_now < interp) ? (interp - phase_now + decim - 1) / decim : 0;
      capped = (total > MAX_OUTPUTS);
      // Dropped outputs still step the phase.
      while (phase_now < interp) begin
         if (batch.size() < MAX_OUTPUTS) begin
            acc = 0;
            for (k = 0; k < taps; k++) begin
               src = (newest + taps - k) % taps;
               if (phase_now < MAX_PHASES)
                  acc += longint'(hist_line[src]) *
                         longint'(coef_store[phase_now * MAX_TAPS + k]);
            end
            if (cfg_shift != 0)
               acc += longint'(1) << (cfg_shift - 1);
            acc = acc >>> cfg_shift;
            item.saturated = 1'b0;
            if (acc > 32767) begin
               item.out_sample = OUT_MAX;
               item.saturated = 1'b1;
            end else if (acc < -32768) begin
               item.out_sample = OUT_MIN;
               item.saturated = 1'b1;
            end else begin
               item.out_sample = acc[15:0];
            end
            item.last = 1'b0;
            item.capped = capped;
            batch.push_back(item);
         end
         phase_now += decim;
      end
      phase_now = (phase_now - interp) & 9'h1FF;
      produced = batch.size();
      first_out = (produced > 0) ? batch[0] : '0;
      for (k = 0; k < produced; k++) begin
         item = batch[k];
         item.last = (k == produced - 1);
         expected_outputs.push_back(item);
      end
   endtask

   // Apply one accepted request to the predictor.
   task automatic model_request(input logic [1:0] mode, input logic [47:0] data,
                                output int produced, output resample_out_t first_out);
      produced = 0;
      first_out = '0;
      case (mode)
         MODE_SAMPLE: resample_input(data[15:0], produced, first_out);
         MODE_COEF: coef_store[{data[23:16], data[28:24]}] = data[46:29];
         MODE_CLEAR: begin
            foreach (hist_line[i])
               hist_line[i] = '0;
            hist_pos = 0;
            phase_now = 0;
         end
         default: ;
      endcase
   endtask

   // Offer one request, optionally after an idle gap, and wait until it is taken.
   task automatic send_request(input logic [1:0] mode, input logic [47:0] data,
                               input bit paced, output int produced,
                               output resample_out_t first_out);
      int gap;
      gap = paced ? idle_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      model_request(mode, data, produced, first_out);
   endtask

   // Back-to-back register writes keep psel high; the caller drops it afterwards.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      case (index)
         REG_INTERP: cfg_interp = value[8:0];
         REG_DECIM:  cfg_decim  = value[8:0];
         REG_TAPS:   cfg_taps   = value[5:0];
         REG_SHIFT:  cfg_shift  = value[4:0];
         default: ;
      endcase
   endtask

   // Stop requesting, wait for every expected output, then let the block go idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      stim_row_t     directed_rows [NUM_DIRECTED];
      setting_t      settings [NUM_SETTINGS];
      resample_out_t first_out;
      int            produced;
      int            i;
      int            s;
      int            pick;
      int            interp;
      int            taps;
      logic [31:0]   rnd;
      logic [15:0]   sval;
      logic [17:0]   cval;
      logic [1:0]    mode;
      logic [47:0]   data;

      // Directed table, run under the reset register values.
      directed_rows[0]  = '{MODE_SAMPLE, 16'h7FFF, 8'd0, 5'd0, 18'h0,
                            1'b1, 5'd2, 16'h0000, 1'b0};
      directed_rows[1]  = '{MODE_COEF, 16'h0, 8'd0, 5'd0, 18'h1FFFF, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[2]  = '{MODE_COEF, 16'h0, 8'd255, 5'd31, 18'h20000, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[3]  = '{MODE_COEF, 16'h0, 8'd134, 5'd0, 18'h04000, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[4]  = '{MODE_SAMPLE, 16'h8000, 8'd0, 5'd0, 18'h0,
                            1'b1, 5'd1, 16'h8000, 1'b0};
      directed_rows[5]  = '{MODE_UNUSED, 16'hFFFF, 8'hAA, 5'd15, 18'h2AAAA,
                            1'b1, 5'd0, 16'h0, 1'b0};
      directed_rows[6]  = '{MODE_COEF, 16'h0, 8'd121, 5'd1, 18'h3C000, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[7]  = '{MODE_SAMPLE, 16'h1234, 8'd0, 5'd0, 18'h0,
                            1'b1, 5'd1, 16'h7FFF, 1'b1};
      directed_rows[8]  = '{MODE_CLEAR, 16'h0, 8'd0, 5'd0, 18'h0, 1'b1, 5'd0, 16'h0, 1'b0};
      directed_rows[9]  = '{MODE_SAMPLE, 16'h7FFF, 8'd0, 5'd0, 18'h0,
                            1'b1, 5'd2, 16'h7FFF, 1'b1};
      directed_rows[10] = '{MODE_COEF, 16'h0, 8'd0, 5'd1, 18'h15555, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[11] = '{MODE_COEF, 16'h0, 8'd147, 5'd1, 18'h2AAAA, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[12] = '{MODE_SAMPLE, 16'h0000, 8'd0, 5'd0, 18'h0,
                            1'b1, 5'd1, 16'h0000, 1'b0};
      directed_rows[13] = '{MODE_SAMPLE, 16'h5555, 8'd0, 5'd0, 18'h0, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[14] = '{MODE_SAMPLE, 16'hAAAA, 8'd0, 5'd0, 18'h0, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[15] = '{MODE_SAMPLE, 16'h0001, 8'd0, 5'd0, 18'h0, 1'b0, 5'd0, 16'h0, 1'b0};
      directed_rows[16] = '{MODE_SAMPLE, 16'hFFFF, 8'd0, 5'd0, 18'h0, 1'b0, 5'd0, 16'h0, 1'b0};

      // Register settings: extremes, out-of-range values that clamp, capped and uncapped.
      settings[0] = '{32'd1,   32'd1,   32'd4,  32'd0,  16'd25};
      settings[1] = '{32'd256, 32'd1,   32'd32, 32'd31, 16'd12};
      settings[2] = '{32'd0,   32'd3,   32'd0,  32'd14, 16'd25};
      settings[3] = '{32'd300, 32'd511, 32'd63, 32'd15, 16'd25};
      settings[4] = '{32'd7,   32'd3,   32'd17, 32'd13, 16'd25};
      settings[5] = '{32'd2,   32'd5,   32'd3,  32'd12, 16'd25};
      settings[6] = '{32'd17,  32'd1,   32'd8,  32'd9,  16'd15};
      settings[7] = '{32'd16,  32'd1,   32'd31, 32'd5,  16'd15};
      settings[8] = '{32'd160, 32'd147, 32'd32, 32'd14, 16'd25};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero every coefficient so that no branch ever reads an unwritten entry.
      for (i = 0; i < MAX_PHASES * MAX_TAPS; i++)
         send_request(MODE_COEF, pack_request(16'h0, i[12:5], i[4:0], 18'h0), 1'b0,
                      produced, first_out);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         send_request(directed_rows[i].mode,
                      pack_request(directed_rows[i].sample, directed_rows[i].coef_phase,
                                   directed_rows[i].coef_index, directed_rows[i].coef_value),
                      1'b1, produced, first_out);
         if (directed_rows[i].known &&
             (produced != directed_rows[i].known_count ||
              (produced > 0 && (first_out.out_sample !== directed_rows[i].known_sample ||
                                first_out.saturated !== directed_rows[i].known_sat))))
            note_error($sformatf("directed row %0d: predicted %0d outputs, first %h sat %b",
                                 i, produced, first_out.out_sample, first_out.saturated));
      end
      settle();

      // Random traffic under each register setting.
      for (s = 0; s < NUM_SETTINGS; s++) begin
         write_register(REG_INTERP, settings[s].interp);
         write_register(REG_DECIM, settings[s].decim);
         write_register(REG_TAPS, settings[s].taps);
         write_register(REG_SHIFT, settings[s].shift);
         csr_psel <= 1'b0;
         csr_pwrite <= 1'b0;
         interp = clamp_int(cfg_interp, 1, 256);
         taps = clamp_int(cfg_taps, 4, MAX_TAPS);
         for (i = 0; i < settings[s].requests; i++) begin
            pick = $urandom_range(0, 99);
            rnd = $urandom;
            sval = rnd[15:0];
            if ($urandom_range(0, 99) < 12) begin
               case ($urandom_range(0, 3))
                  0: sval = 16'h7FFF;
                  1: sval = 16'h8000;
                  2: sval = 16'h0000;
                  default: sval = 16'hFFFF;
               endcase
            end
            cval = ($urandom_range(0, 99) < 15) ? rnd[31:14]
                                                : 18'($urandom_range(0, 8191)) - 18'd4096;
            rnd = $urandom;
            if (pick < 62) begin
               mode = MODE_SAMPLE;
               data = pack_request(sval, rnd[7:0], rnd[12:8], rnd[30:13]);
            end else if (pick < 86) begin
               // Coefficient for a branch and tap that this setting reads.
               mode = MODE_COEF;
               data = pack_request(sval, 8'($urandom_range(0, interp - 1)),
                                   5'($urandom_range(0, taps - 1)), cval);
            end else if (pick < 91) begin
               mode = MODE_COEF;
               data = pack_request(sval, rnd[7:0], rnd[12:8], rnd[30:13]);
            end else if (pick < 95) begin
               mode = MODE_CLEAR;
               data = pack_request(sval, rnd[7:0], rnd[12:8], rnd[30:13]);
            end else begin
               mode = MODE_UNUSED;
               data = pack_request(sval, rnd[7:0], rnd[12:8], rnd[30:13]);
            end
            send_request(mode, data, 1'b1, produced, first_out);
         end
         settle();
      end

      if (expected_outputs.size() != 0)
         note_error($sformatf("%0d expected outputs never arrived", expected_outputs.size()));
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
